@@ src/tdps_pkg.sv @@
// Package for the tail-drop packet scheduler.
// Shared field widths, configuration reset value and sequencer state type.
// No dependencies.
package tdps_pkg;

  localparam int FIELD_W = 32;
  localparam int CFG_W   = 11;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CMP
  } tdps_state_t;

endpackage

@@ src/tdps_req_if.sv @@
// Request channel interface: arrival and processing time of one packet.
// Depends on tdps_pkg for field widths.
interface tdps_req_if
  import tdps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] arrival;
  logic [FIELD_W-1:0] service;

  modport source (output valid, output arrival, output service, input ready);
  modport sink   (input valid, input arrival, input service, output ready);
endinterface

@@ src/tdps_res_if.sv @@
// Result channel interface: drop flag and start time of one packet.
// Depends on tdps_pkg for field widths.
interface tdps_res_if
  import tdps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               dropped;
  logic [FIELD_W-1:0] start;

  modport source (output valid, output dropped, output start, input ready);
  modport sink   (input valid, input dropped, input start, output ready);
endinterface

@@ src/tdps_store.sv @@
// Finish-time store: single-port-write, single-read synchronous RAM.
// Registered read with write-to-read forwarding on the same address.
module tdps_store #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/tdps_sched.sv @@
// Scheduler sequencer: FIFO pointers, pop loop against the store, push and result register.
// Depends on tdps_pkg; drives the port of tdps_store.
module tdps_sched
  import tdps_pkg::*;
#(
  parameter int MAX_DEPTH  = 1024,
  parameter int TIME_WIDTH = 32,
  parameter int ADDR_W     = 10,
  parameter int OCC_W      = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FIELD_W-1:0]    in_arrival,
  input  logic [FIELD_W-1:0]    in_process,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_dropped,
  output logic [FIELD_W-1:0]    out_start,
  input  logic [CFG_W-1:0]      buffer_size,
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_waddr,
  output logic [TIME_WIDTH-1:0] mem_wdata,
  output logic [ADDR_W-1:0]     mem_raddr,
  input  logic [TIME_WIDTH-1:0] mem_rdata
);

  localparam int LIM_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_DEPTH - 1);
  localparam logic [LIM_W-1:0]  MAX_LIM   = LIM_W'(MAX_DEPTH);

  tdps_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]     head_r, head_nxt;
  logic [ADDR_W-1:0]     tail_r, tail_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic [TIME_WIDTH-1:0] last_r, last_nxt;
  logic [TIME_WIDTH-1:0] arr_r, arr_nxt;
  logic [TIME_WIDTH-1:0] proc_r, proc_nxt;
  logic [TIME_WIDTH-1:0] start_r, start_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_dropped_r, out_dropped_nxt;
  logic [FIELD_W-1:0]    out_start_r, out_start_nxt;

  logic [TIME_WIDTH-1:0] in_arr_t;
  logic [TIME_WIDTH-1:0] avail;
  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] finish;
  logic [LIM_W-1:0]      limit;
  logic                  full;
  logic                  pop;
  logic                  can_load;

  assign in_arr_t = TIME_WIDTH'(in_arrival);
  assign avail    = (occ_r != '0) ? last_r : '0;
  assign sum      = {1'b0, start_r} + {1'b0, proc_r};
  assign finish   = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
  assign limit    = (LIM_W'(buffer_size) > MAX_LIM) ? MAX_LIM : LIM_W'(buffer_size);
  assign full     = LIM_W'(occ_r) >= limit;
  assign pop      = (occ_r != '0) && (mem_rdata <= arr_r);
  assign can_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r        <= last_nxt;
    arr_r         <= arr_nxt;
    proc_r        <= proc_nxt;
    start_r       <= start_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_start_r   <= out_start_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    occ_nxt         = occ_r;
    last_nxt        = last_r;
    arr_nxt         = arr_r;
    proc_nxt        = proc_r;
    start_nxt       = start_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_dropped_nxt = out_dropped_r;
    out_start_nxt   = out_start_r;
    in_ready        = 1'b0;
    mem_we          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          arr_nxt   = in_arr_t;
          proc_nxt  = TIME_WIDTH'(in_process);
          // start is fixed by the newest entry before any pops
          start_nxt = (avail > in_arr_t) ? avail : in_arr_t;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (pop) begin
          head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
          occ_nxt  = occ_r - 1'b1;
        end else if (can_load) begin
          out_valid_nxt   = 1'b1;
          out_dropped_nxt = full;
          out_start_nxt   = full ? '0 : FIELD_W'(start_r);
          if (!full) begin
            mem_we   = 1'b1;
            tail_nxt = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
            occ_nxt  = occ_r + 1'b1;
            last_nxt = finish;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // read always targets the next head, so the compare stage sees the current head entry
  assign mem_raddr   = head_nxt;
  assign mem_waddr   = tail_r;
  assign mem_wdata   = finish;
  assign out_valid   = out_valid_r;
  assign out_dropped = out_dropped_r;
  assign out_start   = out_start_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(occ_r) <= MAX_LIM)
    else $error("occupancy above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> (head_r == tail_r))
    else $error("empty FIFO with head and tail apart");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (LIM_W'(occ_r) < limit))
    else $error("push into a full buffer");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((occ_r == $past(occ_r)) || (occ_r == $past(occ_r) + 1'b1)
                      || (occ_r + 1'b1 == $past(occ_r))))
    else $error("occupancy moved by more than one");

endmodule

@@ src/tail_drop_packet_scheduler_unit.sv @@
// Tail-drop packet scheduler, top level.
// Channels: in_req (sink) takes one request of arrival and service time;
// out_res (source) returns one result per request: dropped flag and start.
// Configuration: cfg_we with cfg_wdata writes buffer_size (reset 1024); values above
// MAX_DEPTH act as MAX_DEPTH, zero drops every packet. Write only while idle.
// Finish times of accepted packets live in a MAX_DEPTH-entry synchronous RAM
// used as a circular FIFO; the head entry is read ahead through the registered read port and compared.
// A request is taken while idle, then pops each entry that has finished by its arrival
// (one pop per cycle, set by the single RAM read port), then loads its result. The result
// is registered and shows on out_res the cycle after the request finishes.
// in_req.ready is high only while the sequencer is idle; the result register lets
// the next request be taken while a result still waits. A stalled receiver holds the
// result; a following request then waits in its last step until the register frees.
// Reset (rst_n, synchronous) empties the FIFO and restores buffer_size; the RAM is
// not cleared, as only entries within occupancy are ever read.
module tail_drop_packet_scheduler_unit
  import tdps_pkg::*;
#(
  parameter int MAX_DEPTH  = 1024,
  parameter int TIME_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  tdps_req_if.sink         in_req,
  tdps_res_if.source       out_res,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int OCC_W  = $clog2(MAX_DEPTH + 1);

  logic [CFG_W-1:0]      buffer_size_r, buffer_size_nxt;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [TIME_WIDTH-1:0] mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [TIME_WIDTH-1:0] mem_rdata;

  assign buffer_size_nxt = cfg_we ? cfg_wdata : buffer_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= CFG_SIZE_RESET;
    end else begin
      buffer_size_r <= buffer_size_nxt;
    end
  end

  tdps_sched #(
    .MAX_DEPTH  (MAX_DEPTH),
    .TIME_WIDTH (TIME_WIDTH),
    .ADDR_W     (ADDR_W),
    .OCC_W      (OCC_W)
  ) u_sched (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_arrival  (in_req.arrival),
    .in_process  (in_req.service),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .out_dropped (out_res.dropped),
    .out_start   (out_res.start),
    .buffer_size (buffer_size_r),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  tdps_store #(
    .DEPTH  (MAX_DEPTH),
    .DATA_W (TIME_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for tail_drop_packet_scheduler_unit: directed and random requests,
// predicted in a scoreboard class and compared field by field on the result channel.
// Depends on tdps_pkg, tdps_req_if and tdps_res_if.
module tb_top
  import tdps_pkg::*;
();

  localparam int QUEUE_DEPTH = 1024;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 125;
  localparam int NOISE_ITEMS = 13;
  localparam logic [FIELD_W-1:0] TIME_MAX = '1;
  localparam logic [CFG_W-1:0] SIZE_DROP_ALL = '0;

  typedef struct packed {
    logic               dropped;
    logic [FIELD_W-1:0] start;
  } sched_result_t;

  // Tracks the finish-time FIFO and buffer size, predicts each request's result.
  class tail_drop_scoreboard;
    logic [FIELD_W-1:0] finish_times[$];
    sched_result_t      expected_results[$];
    logic [CFG_W-1:0]   buffer_size;
    int                 errors;

    function new();
      buffer_size = CFG_SIZE_RESET;
      errors = 0;
    endfunction

    function void set_size(logic [CFG_W-1:0] size);
      buffer_size = size;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(logic [FIELD_W-1:0] arrival, logic [FIELD_W-1:0] proc);
      logic [FIELD_W-1:0] newest;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W:0]   sum;
      int                 limit;
      sched_result_t      res;
      // newest finish is taken before the pops
      newest = (finish_times.size() > 0) ? finish_times[$] : '0;
      limit = (buffer_size > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(buffer_size);
      while (finish_times.size() > 0 && finish_times[0] <= arrival)
        finish_times.delete(0);
      if (finish_times.size() >= limit) begin
        res.dropped = 1'b1;
        res.start = '0;
      end else begin
        start = (newest > arrival) ? newest : arrival;
        sum = {1'b0, start} + {1'b0, proc};
        finish_times.push_back(sum[FIELD_W] ? TIME_MAX : sum[FIELD_W-1:0]);
        res.dropped = 1'b0;
        res.start = start;
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(logic dropped, logic [FIELD_W-1:0] start_val);
      sched_result_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: dropped=%0b start=%0h",
                 $time, dropped, start_val);
        errors++;
        return;
      end
      exp_res = expected_results[0];
      expected_results.delete(0);
      if (exp_res.dropped !== dropped) begin
        $display("%0t: dropped mismatch: expected %0b, actual %0b",
                 $time, exp_res.dropped, dropped);
        errors++;
      end
      if (exp_res.start !== start_val) begin
        $display("%0t: start mismatch: expected %0h, actual %0h",
                 $time, exp_res.start, start_val);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  tdps_req_if req_if ();
  tdps_res_if res_if ();

  tail_drop_scoreboard sb;

  int send_idle_pct;
  int recv_idle_pct;
  int res_count = 0;
  int hold_left = 0;
  int phase_sizes[PHASES];

  tail_drop_packet_scheduler_unit #(
    .MAX_DEPTH (QUEUE_DEPTH),
    .TIME_WIDTH(FIELD_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result monitor and receiver ready; two long hold-offs back up the block.
  always @(posedge clk) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      sb.check_result(res_if.dropped, res_if.start);
      res_count++;
      if (res_count == 300 || res_count == 1300)
        hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input logic [FIELD_W-1:0] arrival,
                              input logic [FIELD_W-1:0] proc);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40)
      gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.arrival <= arrival;
    req_if.service <= proc;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(arrival, proc);
  endtask

  // Buffer size may change only with nothing in flight.
  task automatic write_buffer_size(input logic [CFG_W-1:0] size);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_size(size);
  endtask

  // Size zero plus an arrival at the top of the range pops everything and drops.
  task automatic empty_buffer();
    write_buffer_size(SIZE_DROP_ALL);
    send_request(TIME_MAX, $urandom);
  endtask

  initial begin
    logic [FIELD_W-1:0] now;
    logic [FIELD_W-1:0] arr;
    logic [FIELD_W-1:0] proc;
    int                 proc_max;
    int                 pick;
    int                 back;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.arrival = '0;
    req_if.service = '0;
    send_idle_pct = 8;
    recv_idle_pct = 82;
    phase_sizes = '{3, 1, 1024, 16, 2047, 2, 64, 5, 1024, 8, 1, 300};
    sb = new();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty buffer, pops, backwards arrival, saturation at the top
    send_request(0, 0);
    send_request(0, 10);
    send_request(5, 20);
    send_request(5, 0);
    send_request(100, 7);
    send_request(50, 1);
    send_request(TIME_MAX - 15, TIME_MAX);
    send_request(TIME_MAX, 5);
    send_request(TIME_MAX, 0);
    // size zero drops everything
    write_buffer_size(SIZE_DROP_ALL);
    send_request(20, 3);
    send_request(TIME_MAX, TIME_MAX);
    // oversize limit saturates at the queue depth
    write_buffer_size('1);
    send_request(TIME_MAX, 1);
    send_request(0, 100);
    write_buffer_size(4);
    send_request(0, 50);
    send_request(0, 0);
    send_request(0, 0);
    // size lowered under a full buffer: drops until pops make room
    write_buffer_size(2);
    send_request(0, 0);
    send_request(TIME_MAX, 0);
    write_buffer_size(1);
    send_request(10, 5);
    send_request(TIME_MAX, 0);
    empty_buffer();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 8;
      end
      if (ph == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_buffer_size(phase_sizes[ph][CFG_W-1:0]);
      now = $urandom_range(0, 32'h3FFF_FFFF);
      proc_max = $urandom_range(10, 60);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (n < PHASE_ITEMS - NOISE_ITEMS) begin
          // steady traffic with ~2x load so the buffer fills and drops
          proc = $urandom_range(0, proc_max);
          if (pick < 85) begin
            arr = now + $urandom_range(0, 20);
            now = arr;
          end else if (pick < 93) begin
            arr = now + $urandom_range(20, 2000);
            now = arr;
          end else begin
            back = $urandom_range(0, 30);
            arr = (now >= back) ? now - back : now;
          end
        end else begin
          // tail of the phase: full-range values and saturating finishes
          if (pick < 30) begin
            arr = $urandom;
            proc = $urandom;
          end else if (pick < 55) begin
            arr = TIME_MAX - $urandom_range(0, 64);
            proc = $urandom;
          end else if (pick < 80) begin
            arr = now - $urandom_range(0, 32'h0FFF_FFFF);
            proc = $urandom_range(0, proc_max);
          end else begin
            arr = now;
            proc = TIME_MAX;
          end
          now = arr;
        end
        send_request(arr, proc);
      end
      empty_buffer();
    end

    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
